// ----- design/uvsph_pkg.sv -----
package uvsph_pkg;

  // Field and register widths
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IDX_W     = 16;

  // Default largest line count
  localparam int unsigned MAX_LINES_DEF = 256;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_IDX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LON_IDX = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] LAT_RESET = 9'd10;
  localparam logic [CFG_W-1:0] LON_RESET = 9'd10;

endpackage

// ----- design/uvsph_if.sv -----
interface uvsph_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface uvsph_out_if;
  logic                        valid;
  logic                        ready;
  logic [uvsph_pkg::IDX_W-1:0] corner_a;
  logic [uvsph_pkg::IDX_W-1:0] corner_b;
  logic [uvsph_pkg::IDX_W-1:0] corner_c;
  logic                        last_triangle;

  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output last_triangle, input ready);
  modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                  input last_triangle, output ready);
endinterface

// ----- design/uv_sphere_triangle_index_generator.sv -----
// Each input transfer loads its triangle into the result register.
// Throughput: one triangle per cycle unless the output stalls; counter and index
// arithmetic (one small multiply for the bottom pole) is combinational.
// A new item is taken while the result register is empty or being drained.
// Reset: asynchronous, active low; counters return to the first top-cap
// triangle and both line counts return to 10.
module uv_sphere_triangle_index_generator #(
  parameter int unsigned MAX_LINES = uvsph_pkg::MAX_LINES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [uvsph_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [uvsph_pkg::CFG_W-1:0]     cfg_data_i,
  uvsph_in_if.sink                        in_i,
  uvsph_out_if.source                     out_o
);

  localparam int unsigned LINE_W = $clog2(MAX_LINES + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_LINES);
  localparam int unsigned MUL_W  = 2 * LINE_W;
  localparam int unsigned IW     = uvsph_pkg::IDX_W;

  typedef enum logic [1:0] {
    PH_TOP,
    PH_BAND,
    PH_BOTTOM
  } phase_e;

  logic [uvsph_pkg::CFG_W-1:0] lat_cfg_q, lon_cfg_q;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] ring_q, ring_d;
  logic             half_q, half_d;
  logic [IW-1:0]    base_q, base_d;

  logic          out_valid_q;
  logic [IW-1:0] a_q, b_q, c_q, a_d, b_d, c_d;
  logic          last_q, last_d;

  logic in_fire;

  function automatic logic [LINE_W-1:0] clamp_lines(logic [uvsph_pkg::CFG_W-1:0] v);
    if (32'(v) < 32'd3) begin
      return LINE_W'(3);
    end else if (32'(v) > MAX_LINES) begin
      return LINE_W'(MAX_LINES);
    end else begin
      return LINE_W'(v);
    end
  endfunction

  // Handshake: take a new item while the result register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_cfg_q <= uvsph_pkg::LAT_RESET;
      lon_cfg_q <= uvsph_pkg::LON_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uvsph_pkg::CFG_LAT_IDX: lat_cfg_q <= cfg_data_i;
        uvsph_pkg::CFG_LON_IDX: lon_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [LINE_W-1:0] lat, lon, lon_m1, bands;
  logic              clear;
  phase_e            ph_eff;
  logic [CNT_W-1:0]  col_eff, ring_eff, col_use;
  logic              half_eff;
  logic [IW-1:0]     base_eff;
  logic              wrap;
  logic [IW-1:0]     col_p1, next_idx, lon_idx;
  logic [IW-1:0]     up, upn, dn, dnn, top;
  logic [MUL_W-1:0]  prod;
  logic [CNT_W:0]    ring_p1;

  // Index arithmetic for the current triangle
  always_comb begin
    lat    = clamp_lines(lat_cfg_q);
    lon    = clamp_lines(lon_cfg_q);
    lon_m1 = lon - LINE_W'(1);
    bands  = lat - LINE_W'(3);

    clear    = in_i.restart || !(phase_q == PH_TOP || phase_q == PH_BAND ||
                                 phase_q == PH_BOTTOM);
    ph_eff   = clear ? PH_TOP : phase_q;
    col_eff  = clear ? '0 : col_q;
    ring_eff = clear ? '0 : ring_q;
    half_eff = clear ? 1'b0 : half_q;
    base_eff = clear ? '0 : base_q;

    // Clip a column beyond the ring to its last column
    wrap     = LINE_W'(col_eff) >= lon_m1;
    col_use  = wrap ? CNT_W'(lon_m1) : col_eff;
    col_p1   = IW'(col_use) + IW'(1);
    next_idx = wrap ? IW'(1) : IW'(col_use) + IW'(2);
    lon_idx  = IW'(lon);

    up  = base_eff + col_p1;
    upn = base_eff + next_idx;
    dn  = base_eff + lon_idx + col_p1;
    dnn = base_eff + lon_idx + next_idx;

    prod = MUL_W'(lat - LINE_W'(2)) * MUL_W'(lon);
    top  = IW'(prod) + IW'(1);

    ring_p1 = {1'b0, ring_eff} + (CNT_W + 1)'(1);

    phase_d = ph_eff;
    col_d   = col_eff;
    ring_d  = ring_eff;
    half_d  = half_eff;
    base_d  = base_eff;
    a_d     = '0;
    b_d     = '0;
    c_d     = '0;
    last_d  = 1'b0;

    case (ph_eff)
      PH_TOP: begin
        a_d = '0;
        b_d = col_p1;
        c_d = next_idx;
        if (wrap) begin
          col_d   = '0;
          half_d  = 1'b0;
          ring_d  = '0;
          base_d  = '0;
          phase_d = (lat > LINE_W'(3)) ? PH_BAND : PH_BOTTOM;
        end else begin
          col_d = col_use + CNT_W'(1);
        end
      end
      PH_BAND: begin
        if (!half_eff) begin
          a_d    = up;
          b_d    = upn;
          c_d    = dn;
          half_d = 1'b1;
        end else begin
          a_d    = dn;
          b_d    = upn;
          c_d    = dnn;
          half_d = 1'b0;
          if (wrap) begin
            col_d  = '0;
            base_d = base_eff + lon_idx;
            if (32'(ring_p1) >= 32'(bands)) begin
              ring_d  = '0;
              phase_d = PH_BOTTOM;
            end else begin
              ring_d = CNT_W'(ring_p1);
            end
          end else begin
            col_d = col_use + CNT_W'(1);
          end
        end
      end
      default: begin
        // Bottom cap: reverse fan around the last vertex
        a_d = top;
        b_d = top - col_p1;
        c_d = top - next_idx;
        if (wrap) begin
          last_d  = 1'b1;
          phase_d = PH_TOP;
          col_d   = '0;
          ring_d  = '0;
          half_d  = 1'b0;
          base_d  = '0;
        end else begin
          col_d = col_use + CNT_W'(1);
        end
      end
    endcase
  end

  // Advance the counters and load the result register on each input transfer;
  // drop the result after its output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TOP;
      col_q       <= '0;
      ring_q      <= '0;
      half_q      <= 1'b0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      last_q      <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      col_q       <= col_d;
      ring_q      <= ring_d;
      half_q      <= half_d;
      base_q      <= base_d;
      out_valid_q <= 1'b1;
      a_q         <= a_d;
      b_q         <= b_d;
      c_q         <= c_d;
      last_q      <= last_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.corner_a      = a_q;
  assign out_o.corner_b      = b_q;
  assign out_o.corner_c      = c_q;
  assign out_o.last_triangle = last_q;

  // Every input transfer leaves a triangle waiting
  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("input transfer did not load the result register");

  // No triangle appears without an input transfer
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && !out_valid_q) |=> !out_valid_q)
    else $error("result appeared without an input transfer");

  // After the final triangle the mesh starts again from the top cap
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_d) |=> (phase_q == PH_TOP && col_q == '0 && base_q == '0))
    else $error("counters not cleared after the final triangle");

endmodule
